>>> design/rrq_pkg.sv
// rrq_pkg: shared types and constants of the round-robin run queue
// no dependencies; used by every module of the block
`default_nettype none

package rrq_pkg;

  // queue depth and widths
  localparam int TASKS  = 16;
  localparam int TASK_W = 4;
  localparam int CNT_W  = $clog2(TASKS + 1);
  localparam int OUT_CNT_W = 5;

  // stream widths
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 16;

  // operation codes
  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_REMOVE = 2'd1,
    OP_MOVE   = 2'd2
  } op_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_NOCHANGE = 2'd1,
    ST_FULL     = 2'd2,
    ST_DUP      = 2'd3
  } status_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;    // capture the incoming operation
    logic commit;  // apply the operation and write the result register
  } rrq_cmd_t;

endpackage

`default_nettype wire

>>> design/rrq_ctrl.sv
// rrq_ctrl: controller state machine of the run queue
// depends on rrq_pkg; drives rrq_datapath through rrq_cmd_t
`default_nettype none

module rrq_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            s_tvalid,
  output logic                 s_tready,
  output logic                 m_tvalid,
  input  wire logic            m_tready,
  output rrq_pkg::rrq_cmd_t    cmd
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state;
  logic   out_free;

  // output register can take a new result this cycle
  assign out_free   = !m_tvalid || m_tready;
  assign s_tready   = (state == S_IDLE);
  assign cmd.load   = s_tvalid && s_tready;
  assign cmd.commit = (state == S_EXEC) && out_free;

  // state and result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd.load) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (cmd.commit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

>>> design/rrq_datapath.sv
// rrq_datapath: slot chain, match and compaction logic, result register
// depends on rrq_pkg; commanded by rrq_ctrl
`default_nettype none

module rrq_datapath (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire rrq_pkg::rrq_cmd_t              cmd,
  input  wire logic [rrq_pkg::IN_DATA_W-1:0]  in_data,
  output logic      [rrq_pkg::OUT_DATA_W-1:0] out_data
);

  localparam int TASKS  = rrq_pkg::TASKS;
  localparam int TASK_W = rrq_pkg::TASK_W;
  localparam int CNT_W  = rrq_pkg::CNT_W;

  // queue state
  logic [TASK_W-1:0] slots [TASKS];
  logic [TASKS-1:0]  valid;
  logic [CNT_W-1:0]  count;

  // captured operation
  logic [1:0]        op_q;
  logic [TASK_W-1:0] task_q;

  // next state
  logic [TASK_W-1:0] slots_next [TASKS];
  logic [TASKS-1:0]  valid_next;
  logic [CNT_W-1:0]  count_next;

  logic [TASKS-1:0]  match;
  logic [TASKS-1:0]  after;
  logic [TASKS-1:0]  tail_free;
  logic [TASKS-1:0]  valid_up;
  logic              found;
  logic              at_last;
  logic              full;
  logic              do_app;
  logic              do_shift;
  logic              do_rem;
  rrq_pkg::status_t  status;
  logic [TASK_W-1:0] head;

  // compare every slot against the named task
  always_comb begin
    logic acc;
    acc = 1'b0;
    for (int i = 0; i < TASKS; i++) begin
      match[i] = valid[i] && (slots[i] == task_q);
      acc      = acc | match[i];
      after[i] = acc;
    end
  end

  // valid bits shifted one place toward the head
  assign valid_up = {1'b0, valid[TASKS-1:1]};

  // first free slot at the tail
  always_comb begin
    for (int i = 0; i < TASKS; i++) begin
      if (i == 0) begin
        tail_free[i] = !valid[i];
      end else begin
        tail_free[i] = !valid[i] && valid[i-1];
      end
    end
  end

  assign found   = |match;
  assign at_last = |(match & ~valid_up);
  assign full    = (count >= CNT_W'(TASKS));

  // operation decode
  always_comb begin
    do_app   = 1'b0;
    do_shift = 1'b0;
    do_rem   = 1'b0;
    status   = rrq_pkg::ST_NOCHANGE;
    case (rrq_pkg::op_t'(op_q))
      rrq_pkg::OP_APPEND: begin
        if (full) begin
          status = rrq_pkg::ST_FULL;
        end else if (found) begin
          status = rrq_pkg::ST_DUP;
        end else begin
          do_app = 1'b1;
          status = rrq_pkg::ST_DONE;
        end
      end
      rrq_pkg::OP_REMOVE: begin
        if (found) begin
          do_shift = 1'b1;
          do_rem   = 1'b1;
          status   = rrq_pkg::ST_DONE;
        end
      end
      rrq_pkg::OP_MOVE: begin
        if (found && !at_last) begin
          do_shift = 1'b1;
          status   = rrq_pkg::ST_DONE;
        end
      end
      default: status = rrq_pkg::ST_NOCHANGE;
    endcase
  end

  // per-slot next value: write at tail or close the gap
  always_comb begin
    for (int i = 0; i < TASKS; i++) begin
      slots_next[i] = slots[i];
      if (do_app && tail_free[i]) begin
        slots_next[i] = task_q;
      end else if (do_shift && after[i]) begin
        if (i < TASKS - 1) begin
          slots_next[i] = valid_up[i] ? slots[(i + 1) % TASKS] : task_q;
        end else begin
          slots_next[i] = task_q;
        end
      end
    end
  end

  // occupancy update
  always_comb begin
    valid_next = valid;
    count_next = count;
    if (do_app) begin
      valid_next = valid | tail_free;
      count_next = count + CNT_W'(1);
    end else if (do_rem) begin
      valid_next = valid_up;
      count_next = count - CNT_W'(1);
    end
  end

  assign head = (count_next != '0) ? slots_next[0] : '0;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      count <= '0;
    end else if (cmd.commit) begin
      valid <= valid_next;
      count <= count_next;
    end
  end

  // slot contents, captured operation and result payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q   <= in_data[1:0];
      task_q <= in_data[2 +: TASK_W];
    end
    if (cmd.commit) begin
      for (int i = 0; i < TASKS; i++) begin
        slots[i] <= slots_next[i];
      end
      out_data <= {4'b0000,
                   rrq_pkg::OUT_CNT_W'(count_next),
                   head,
                   (count_next != '0),
                   status};
    end
  end

endmodule

`default_nettype wire

>>> design/round_robin_run_queue_core.sv
// round_robin_run_queue_core: top level of the round-robin run queue
// depends on rrq_pkg, rrq_ctrl and rrq_datapath
//
// usage:
//   s_* channel takes one operation per transfer: opcode in s_tdata[1:0]
//   (append, remove, move to tail), task number in s_tdata[5:2].
//   m_* channel returns one result per operation: status, head flag,
//   head task and task count after the operation.
//   each operation is captured in the idle state, then executed in a state
//   in which the whole slot chain compares against the task and compacts
//   in place; a result appears on m_tvalid when the execute state commits it.
//   intake stays closed until the previous operation has executed.
//   the result register lets the next operation be captured while a
//   result still waits; the execute cycle holds until the register frees,
//   so a stalled receiver stops intake after one more capture.
//   reset (rst, synchronous) empties the queue and drops m_tvalid;
//   slot contents are not cleared and are only read below the count.
`default_nettype none

module round_robin_run_queue_core (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // opcode[1:0], task_id[5:2], zero [7:6]
  input  wire logic [rrq_pkg::IN_DATA_W-1:0]  s_tdata,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // status[1:0], head_valid[2], head_task[6:3], task_count[11:7], zero [15:12]
  output logic      [rrq_pkg::OUT_DATA_W-1:0] m_tdata
);

  rrq_pkg::rrq_cmd_t cmd;

  // controller
  rrq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  // datapath
  rrq_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_data  (s_tdata),
    .out_data (m_tdata)
  );

endmodule

`default_nettype wire

>>> design/rrq_checker.sv
// rrq_checker: port-level assertions for the run queue top level
// depends on rrq_pkg; bound to round_robin_run_queue_core
`default_nettype none

module rrq_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           s_tvalid,
  input wire logic                           s_tready,
  input wire logic                           m_tvalid,
  input wire logic                           m_tready,
  input wire logic [rrq_pkg::OUT_DATA_W-1:0] m_tdata
);

  // no result is shown right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // head flag agrees with the count
  a_head: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[2] == (m_tdata[11:7] != 5'd0)))
    else $error("head flag disagrees with count");

  // a full status only when the queue is at capacity
  a_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[1:0] == rrq_pkg::ST_FULL) |->
      (m_tdata[11:7] == 5'(rrq_pkg::TASKS)))
    else $error("full status below capacity");

  // the cycle after a capture is spent executing
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("intake open during execute");

endmodule

bind round_robin_run_queue_core rrq_checker u_rrq_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
